@@ rtl/core/perlin_noise_3d_core_assert.svh @@
// ----------------------------------------------------------------------------
// perlin noise core assertion macros
// shared property forms for the core's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_CORE_ASSERT_SVH
`define PERLIN_NOISE_3D_CORE_ASSERT_SVH

// same-cycle implication
`define PNZ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNZ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pnz_pkg.sv @@
// ----------------------------------------------------------------------------
// pnz_pkg
// shared types and constants of the perlin noise core
// ----------------------------------------------------------------------------
package pnz_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_W        = 24;
    localparam int IDX_W          = 8;
    localparam int OUT_W          = 18;
    localparam int OUT_FRAC       = 16;
    localparam int OUT_MAX        = 131071;
    localparam int OUT_MIN        = -131072;
    localparam int QUEUE_DEPTH    = 2;
    localparam int BACK_LAT       = 10;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_opcode;

    typedef struct packed {
        logic               eval;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   val;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
    } t_item;

endpackage

@@ rtl/core/pnz_ram.sv @@
// ----------------------------------------------------------------------------
// pnz_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pnz_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

@@ rtl/core/pnz_front.sv @@
// ----------------------------------------------------------------------------
// pnz_front
// accepts items, classifies load or evaluate, queues them for the back end
// ----------------------------------------------------------------------------
module pnz_front #(
    parameter int QD = pnz_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_opcode,
    input  logic [pnz_pkg::IDX_W-1:0]    i_table_index,
    input  logic [pnz_pkg::IDX_W-1:0]    i_table_value,
    input  logic [pnz_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [pnz_pkg::COORD_W-1:0]  i_coord_y,
    input  logic [pnz_pkg::COORD_W-1:0]  i_coord_z,
    output logic                         o_busy,
    output logic                         o_valid,
    output pnz_pkg::t_item               o_item
);

    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    pnz_pkg::t_item r_q [QD];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           w_push;
    logic           w_pop;
    pnz_pkg::t_item w_new;

    always_comb begin
        w_new.eval = (pnz_pkg::t_opcode'(i_opcode) == pnz_pkg::OP_EVAL);
        w_new.idx  = i_table_index;
        w_new.val  = i_table_value;
        w_new.cx   = i_coord_x;
        w_new.cy   = i_coord_y;
        w_new.cz   = i_coord_z;
    end

    assign o_busy  = (r_cnt == CW'(QD));
    assign w_push  = i_start && !o_busy;
    // back end never stalls, so the head leaves as soon as it is there
    assign w_pop   = (r_cnt != '0);
    assign o_valid = w_pop;
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PW'(QD - 1)) ? '0 : r_wp + PW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(QD - 1)) ? '0 : r_rp + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

endmodule

@@ rtl/core/pnz_back.sv @@
// ----------------------------------------------------------------------------
// pnz_back
// ten-stage evaluate pipeline: table hashing, fade, gradients, interpolation
// ----------------------------------------------------------------------------
module pnz_back #(
    parameter int TABLE_SIZE = pnz_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = pnz_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  pnz_pkg::t_item                     i_item,
    output logic                               o_valid,
    output logic signed [pnz_pkg::OUT_W-1:0]   o_noise_value
);

    localparam int F    = FRAC_BITS;
    localparam int AW   = $clog2(TABLE_SIZE);
    localparam int LAT  = pnz_pkg::BACK_LAT;
    localparam int BW   = F + 4;
    localparam int CW   = F + 2;
    localparam int UW   = F + 1;
    localparam int PW   = 2 * F + 4;
    localparam int OW   = F + 2;
    localparam int GW   = F + 3;
    localparam int DW   = F + 4;
    localparam int LW   = F + 3;
    localparam int LPW  = UW + 1 + DW;
    localparam int UP   = (F < pnz_pkg::OUT_FRAC) ? pnz_pkg::OUT_FRAC - F : 0;
    localparam int DN   = (F > pnz_pkg::OUT_FRAC) ? F - pnz_pkg::OUT_FRAC : 0;
    localparam int SW   = F + 4 + UP;
    localparam int EXTW = pnz_pkg::COORD_W + AW;

    localparam logic [BW-1:0]         K15  = BW'(15 * (2 ** F));
    localparam logic [BW-1:0]         K10  = BW'(10 * (2 ** F));
    localparam logic [PW-1:0]         HALF = PW'(2 ** (F - 1));
    localparam logic signed [OW-1:0]  ONE  = OW'(2 ** F);
    localparam logic [3:0]            H_U_Y  = 4'd8;
    localparam logic [3:0]            H_V_Y  = 4'd4;
    localparam logic [3:0]            H_XZ_A = 4'd12;
    localparam logic [3:0]            H_XZ_B = 4'd14;

    function automatic logic [PW-1:0] rnd_u(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + HALF;
        return s >> F;
    endfunction

    function automatic logic signed [DW-1:0] rnd_s(input logic signed [LPW-1:0] p);
        logic signed [LPW-1:0] s;
        s = p + LPW'(HALF);
        return s[F +: DW];
    endfunction

    function automatic logic signed [LPW-1:0] mul_s(input logic [UW-1:0] t,
                                                    input logic signed [DW-1:0] d);
        logic signed [LPW-1:0] a;
        logic signed [LPW-1:0] b;
        a = {{(LPW-UW){1'b0}}, t};
        b = {{(LPW-DW){d[DW-1]}}, d};
        return a * b;
    endfunction

    function automatic logic signed [GW-1:0] grad(input logic [AW-1:0] hash,
                                                  input logic signed [OW-1:0] x,
                                                  input logic signed [OW-1:0] y,
                                                  input logic signed [OW-1:0] z);
        logic [3:0]            h;
        logic signed [GW-1:0]  gx;
        logic signed [GW-1:0]  gy;
        logic signed [GW-1:0]  gz;
        logic signed [GW-1:0]  uu;
        logic signed [GW-1:0]  vv;
        h  = hash[3:0];
        gx = {x[OW-1], x};
        gy = {y[OW-1], y};
        gz = {z[OW-1], z};
        uu = (h < H_U_Y) ? gx : gy;
        vv = (h < H_V_Y) ? gy : (((h == H_XZ_A) || (h == H_XZ_B)) ? gx : gz);
        return (h[0] ? -uu : uu) + (h[1] ? -vv : vv);
    endfunction

    // stage 0
    logic [pnz_pkg::COORD_W-1:0] w_coord [3];
    logic [AW-1:0]               w_cell  [3];
    logic [F-1:0]                w_frac  [3];
    logic [PW-1:0]               n_p0    [3];
    logic [AW-1:0]               w_r1d   [2];

    // stage 1
    logic                        r_ld1;
    logic [AW-1:0]               r_idx1, r_val1;
    logic [AW-1:0]               r_cy1, r_cz1;
    logic [F-1:0]                r_fr1   [3];
    logic [PW-1:0]               r_p0    [3];
    logic [PW-1:0]               n_p1    [3];
    logic [AW-1:0]               w_ab    [2];
    logic [AW-1:0]               w_r2d   [2][2];

    // stage 2
    logic                        r_ld2;
    logic [AW-1:0]               r_idx2, r_val2;
    logic [AW-1:0]               r_cz2;
    logic [F-1:0]                r_fr2   [3];
    logic [PW-1:0]               r_p1    [3];
    logic [PW-1:0]               n_p2    [3];
    logic [AW-1:0]               w_base  [4];
    logic [AW-1:0]               w_r3d   [4][2];

    // stage 3
    logic [F-1:0]                r_fr3   [3];
    logic [PW-1:0]               r_p2    [3];
    logic [PW-1:0]               n_p3    [3];
    logic signed [OW-1:0]        w_off   [3][2];
    logic signed [GW-1:0]        n_g     [8];

    // stage 4
    logic [PW-1:0]               r_p3    [3];
    logic signed [GW-1:0]        r_g     [8];
    logic [UW-1:0]               w_fade  [3];
    logic signed [LPW-1:0]       n_pl    [4];

    // stages 5 to 9
    logic signed [LPW-1:0]       r_pl5   [4];
    logic signed [GW-1:0]        r_ga5   [4];
    logic [UW-1:0]               r_fv5, r_fw5;
    logic signed [LW-1:0]        n_n     [4];
    logic signed [LW-1:0]        r_n6    [4];
    logic [UW-1:0]               r_fv6, r_fw6;
    logic signed [LPW-1:0]       n_pm    [2];
    logic signed [LPW-1:0]       r_pm7   [2];
    logic signed [LW-1:0]        r_ma7   [2];
    logic [UW-1:0]               r_fw7;
    logic signed [LW-1:0]        n_m     [2];
    logic signed [LW-1:0]        r_m8    [2];
    logic [UW-1:0]               r_fw8;
    logic signed [LPW-1:0]       r_pw9;
    logic signed [LW-1:0]        r_m9;
    logic signed [LW-1:0]        w_r;
    logic signed [SW-1:0]        w_ext;
    logic signed [SW-1:0]        w_scaled;
    logic signed [pnz_pkg::OUT_W-1:0] n_out, r_out;

    logic [LAT-1:0]              r_vld;

    // stage 0: split point, first fade product, level-one table read
    assign w_coord[0] = i_item.cx;
    assign w_coord[1] = i_item.cy;
    assign w_coord[2] = i_item.cz;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cell[a] = AW'(EXTW'({{AW{1'b0}}, w_coord[a]}) >> F);
            w_frac[a] = w_coord[a][F-1:0];
            n_p0[a]   = PW'(w_frac[a]) *
                        PW'(K15 - ({2'b00, w_frac[a], 2'b00} + {3'b000, w_frac[a], 1'b0}));
        end
    end

    pnz_ram #(.WIDTH(AW), .DEPTH(TABLE_SIZE)) u_ram1 (
        .i_clk    (i_clk),
        .i_we     (i_valid && !i_item.eval),
        .i_waddr  (i_item.idx[AW-1:0]),
        .i_wdata  (i_item.val[AW-1:0]),
        .i_raddr0 (w_cell[0]),
        .i_raddr1 (w_cell[0] + AW'(1)),
        .o_rdata0 (w_r1d[0]),
        .o_rdata1 (w_r1d[1])
    );

    // stage 1: A and B rows, level-two reads
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_p1[a] = PW'(r_fr1[a]) * PW'(K10 - BW'(rnd_u(r_p0[a])));
        end
        for (int i = 0; i < 2; i++) begin
            w_ab[i] = w_r1d[i] + r_cy1;
        end
    end

    for (genvar i = 0; i < 2; i++) begin : g_ram2
        pnz_ram #(.WIDTH(AW), .DEPTH(TABLE_SIZE)) u_ram2 (
            .i_clk    (i_clk),
            .i_we     (r_ld1),
            .i_waddr  (r_idx1),
            .i_wdata  (r_val1),
            .i_raddr0 (w_ab[i]),
            .i_raddr1 (w_ab[i] + AW'(1)),
            .o_rdata0 (w_r2d[i][0]),
            .o_rdata1 (w_r2d[i][1])
        );
    end

    // stage 2: AA BA AB BB, level-three reads
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_p2[a] = PW'(r_fr2[a]) * PW'(CW'(rnd_u(r_p1[a])));
        end
        for (int j = 0; j < 4; j++) begin
            w_base[j] = w_r2d[j % 2][j / 2] + r_cz2;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_ram3
        pnz_ram #(.WIDTH(AW), .DEPTH(TABLE_SIZE)) u_ram3 (
            .i_clk    (i_clk),
            .i_we     (r_ld2),
            .i_waddr  (r_idx2),
            .i_wdata  (r_val2),
            .i_raddr0 (w_base[j]),
            .i_raddr1 (w_base[j] + AW'(1)),
            .o_rdata0 (w_r3d[j][0]),
            .o_rdata1 (w_r3d[j][1])
        );
    end

    // stage 3: corner gradients, corner k has x in bit 0, y in bit 1, z in bit 2
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_p3[a]     = PW'(r_fr3[a]) * PW'(CW'(rnd_u(r_p2[a])));
            w_off[a][0] = {2'b00, r_fr3[a]};
            w_off[a][1] = {2'b00, r_fr3[a]} - ONE;
        end
        for (int k = 0; k < 8; k++) begin
            n_g[k] = grad(w_r3d[k % 4][k / 4], w_off[0][k % 2],
                          w_off[1][(k / 2) % 2], w_off[2][k / 4]);
        end
    end

    // stage 4: fades done, x products
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_fade[a] = UW'(rnd_u(r_p3[a]));
        end
        for (int i = 0; i < 4; i++) begin
            n_pl[i] = mul_s(w_fade[0], DW'(r_g[2*i+1]) - DW'(r_g[2*i]));
        end
    end

    // stages 5 to 9: finish x lerps, then y, then z
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_n[i] = LW'(DW'(r_ga5[i]) + rnd_s(r_pl5[i]));
        end
        for (int z = 0; z < 2; z++) begin
            n_pm[z] = mul_s(r_fv6, DW'(r_n6[2*z+1]) - DW'(r_n6[2*z]));
            n_m[z]  = LW'(DW'(r_ma7[z]) + rnd_s(r_pm7[z]));
        end
        w_r   = LW'(DW'(r_m9) + rnd_s(r_pw9));
        w_ext = SW'(w_r);
    end

    if (DN > 0) begin : g_down
        assign w_scaled = (w_ext + SW'(2 ** (DN - 1))) >>> DN;
    end else begin : g_up
        assign w_scaled = w_ext <<< UP;
    end

    always_comb begin
        if (w_scaled > SW'(pnz_pkg::OUT_MAX)) begin
            n_out = pnz_pkg::OUT_W'(pnz_pkg::OUT_MAX);
        end else if (w_scaled < SW'(pnz_pkg::OUT_MIN)) begin
            n_out = pnz_pkg::OUT_W'(pnz_pkg::OUT_MIN);
        end else begin
            n_out = w_scaled[pnz_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ld1 <= 1'b0;
            r_ld2 <= 1'b0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid && i_item.eval};
            r_ld1 <= i_valid && !i_item.eval;
            r_ld2 <= r_ld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_item.idx[AW-1:0];
        r_val1 <= i_item.val[AW-1:0];
        r_cy1  <= w_cell[1];
        r_cz1  <= w_cell[2];
        r_idx2 <= r_idx1;
        r_val2 <= r_val1;
        r_cz2  <= r_cz1;
        for (int a = 0; a < 3; a++) begin
            r_fr1[a] <= w_frac[a];
            r_p0[a]  <= n_p0[a];
            r_fr2[a] <= r_fr1[a];
            r_p1[a]  <= n_p1[a];
            r_fr3[a] <= r_fr2[a];
            r_p2[a]  <= n_p2[a];
            r_p3[a]  <= n_p3[a];
        end
        for (int k = 0; k < 8; k++) begin
            r_g[k] <= n_g[k];
        end
        for (int i = 0; i < 4; i++) begin
            r_pl5[i] <= n_pl[i];
            r_ga5[i] <= r_g[2*i];
            r_n6[i]  <= n_n[i];
        end
        r_fv5 <= w_fade[1];
        r_fw5 <= w_fade[2];
        r_fv6 <= r_fv5;
        r_fw6 <= r_fw5;
        for (int z = 0; z < 2; z++) begin
            r_pm7[z] <= n_pm[z];
            r_ma7[z] <= r_n6[2*z];
            r_m8[z]  <= n_m[z];
        end
        r_fw7 <= r_fw6;
        r_fw8 <= r_fw7;
        r_pw9 <= mul_s(r_fw8, DW'(r_m8[1]) - DW'(r_m8[0]));
        r_m9  <= r_m8[0];
        r_out <= n_out;
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_noise_value = r_out;

endmodule

@@ rtl/core/perlin_noise_3d_core.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_3d_core
// improved 3d gradient noise over a loadable 256-entry permutation table
// ----------------------------------------------------------------------------
// an item is taken on a clock edge with start high and busy low; one item can
// be taken every cycle. a load item (opcode 0) writes one permutation entry
// and gives no result. an evaluate item (opcode 1) gives exactly one result,
// o_noise_value (signed q2.16, saturated), strobed by o_valid for a single
// cycle once the item has left the two-entry input queue and passed the
// evaluate pipeline: three dependent table reads, four fade multiplies and
// three interpolation levels. results come out in item order and cannot be
// held off, so the receiver must take each one in its strobe cycle. loads
// travel down the same pipeline and update each copy of the table at the
// stage that reads it, so an evaluate always sees exactly the loads taken
// before it. every table entry must be loaded before an evaluate reads it.
module perlin_noise_3d_core #(
    parameter int TABLE_SIZE = pnz_pkg::TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = pnz_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic [pnz_pkg::IDX_W-1:0]          i_table_index,
    input  logic [pnz_pkg::IDX_W-1:0]          i_table_value,
    input  logic [pnz_pkg::COORD_W-1:0]        i_coord_x,
    input  logic [pnz_pkg::COORD_W-1:0]        i_coord_y,
    input  logic [pnz_pkg::COORD_W-1:0]        i_coord_z,
    output logic                               o_valid,
    output logic signed [pnz_pkg::OUT_W-1:0]   o_noise_value
);

`include "perlin_noise_3d_core_assert.svh"

    // queue head handed to the back end, popped every cycle it is present
    logic           w_pop;
    pnz_pkg::t_item w_item;
    // an evaluate leaving the queue outside reset, for the checks below
    logic           w_issue;

    pnz_front #(
        .QD (pnz_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .o_busy        (busy),
        .o_valid       (w_pop),
        .o_item        (w_item)
    );

    // back end: hashing, fade and interpolation pipeline
    pnz_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_pop),
        .i_item        (w_item),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

    assign w_issue = w_pop && w_item.eval && i_rst_n;

    // every result comes from an evaluate issued earlier
    `PNZ_ASSERT_IMP(a_result_has_item, o_valid, $past(w_issue, pnz_pkg::BACK_LAT), "result without evaluate item")
    // every issued evaluate yields its result
    `PNZ_ASSERT_IMP(a_item_has_result, $past(w_issue, pnz_pkg::BACK_LAT), o_valid, "evaluate item lost")
    // an item taken into an empty queue is issued on the next cycle
    `PNZ_ASSERT_NXT(a_queue_moves, start && !busy && !w_pop, w_pop, "queued item not issued")

endmodule
